FILE: hdl/dot_star_pattern_matcher_unit_macros.svh
`ifndef DOT_STAR_PATTERN_MATCHER_UNIT_MACROS_SVH
`define DOT_STAR_PATTERN_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define DSPM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dspm assertion failed");

// next-cycle implication
`define DSPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dspm assertion failed");

`endif

FILE: hdl/dspm_pkg.sv
`default_nettype none

package dspm_pkg;

  localparam int MAX_ELEMS = 32;
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int SYM_W     = 8;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;
  localparam logic [1:0] MODE_BYTE   = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_LOAD,
    OP_STEP,
    OP_CLOSE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SYM_W-1:0] symbol;
    logic             any_byte;
    logic             starred;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hdl/dspm_cell.sv
`default_nettype none

module dspm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dspm_pkg::cell_ctrl_t ctrl_i,
  input  logic                wr_i,
  input  logic                used_i,
  input  logic                prev_i,
  output logic                pass_o,
  output logic                act_o
);
  import dspm_pkg::*;

  logic [SYM_W-1:0] sym_q;
  logic             any_q;
  logic             star_q;
  logic             act_q;
  logic             act_d;
  logic             hit;

  // element storage, written once per append
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      sym_q  <= ctrl_i.any_byte ? '0 : ctrl_i.symbol;
      any_q  <= ctrl_i.any_byte;
      star_q <= ctrl_i.starred;
    end
  end

  assign hit = any_q | (sym_q == ctrl_i.symbol);

  always_comb begin
    pass_o = 1'b0;
    act_d  = act_q;
    unique case (ctrl_i.op)
      OP_CLEAR: begin
        act_d = 1'b0;
      end
      OP_LOAD: begin
        act_d = prev_i;
      end
      OP_STEP: begin
        pass_o = act_q & used_i & hit & ~star_q;
        act_d  = (act_q & used_i & hit & star_q) | prev_i;
      end
      OP_CLOSE: begin
        pass_o = act_q & used_i & star_q;
        act_d  = act_q | prev_i;
      end
      default: begin
        act_d = act_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;

endmodule

`default_nettype wire

FILE: hdl/dot_star_pattern_matcher_unit.sv
// clear and append items give no result
// start and byte items: a step in the cell row, then one star-closure
// pass per cycle, with the input stalled, until the active set settles
// result is registered once closure settles and the output register is free
// reset clears the pattern length, active set, overflow flag and output valid
`default_nettype none
`include "dot_star_pattern_matcher_unit_macros.svh"

module dot_star_pattern_matcher_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               mode_i,
  input  logic [dspm_pkg::SYM_W-1:0] symbol_i,
  input  logic                     any_byte_i,
  input  logic                     starred_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     matched_o,
  output logic                     overflow_o
);
  import dspm_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_CLOSE = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             final_q, final_d;
  logic             out_valid_q;
  logic             matched_q;
  logic             overflow_q;

  cell_ctrl_t           ctrl;
  logic                 accept;
  logic                 is_append;
  logic                 out_free;
  logic                 change;
  logic                 done;
  logic [MAX_ELEMS-1:0] pass;
  logic [MAX_ELEMS-1:0] act;
  logic [MAX_ELEMS-1:0] used;
  logic [MAX_ELEMS-1:0] wr;
  logic [MAX_ELEMS:0]   act_all;

  assign accept    = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q == ST_CLOSE);
  assign is_append = accept & (mode_i == MODE_APPEND);
  assign out_free  = ~out_valid_q | ~out_stall_i;

  always_comb begin
    ctrl.op       = OP_HOLD;
    ctrl.symbol   = symbol_i;
    ctrl.any_byte = any_byte_i;
    ctrl.starred  = starred_i;
    state_d       = state_q;
    count_d       = count_q;
    ovf_d         = ovf_q;
    if (state_q == ST_CLOSE) begin
      ctrl.op = OP_CLOSE;
      if (done) begin
        state_d = ST_IDLE;
      end
    end else if (accept) begin
      unique case (mode_i)
        MODE_CLEAR: begin
          ctrl.op = OP_CLEAR;
          count_d = '0;
          ovf_d   = 1'b0;
        end
        MODE_APPEND: begin
          ctrl.op = OP_CLEAR;
          if (count_q == CNT_W'(MAX_ELEMS)) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        MODE_START: begin
          ctrl.op = OP_LOAD;
          state_d = ST_CLOSE;
        end
        MODE_BYTE: begin
          ctrl.op = OP_STEP;
          state_d = ST_CLOSE;
        end
        default: begin
          ctrl.op = OP_HOLD;
        end
      endcase
    end
  end

  // row of position cells, active bits ripple one position per cycle
  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    logic prev;
    assign used[i] = (count_q > CNT_W'(i));
    assign wr[i]   = is_append & (count_q == CNT_W'(i));
    if (i == 0) begin : g_head
      assign prev = (ctrl.op == OP_LOAD);
    end else begin : g_link
      assign prev = pass[i-1];
    end
    dspm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .wr_i   (wr[i]),
      .used_i (used[i]),
      .prev_i (prev),
      .pass_o (pass[i]),
      .act_o  (act[i])
    );
  end

  assign act_all = {final_q, act};
  assign change  = |(pass & ~act_all[MAX_ELEMS:1]);
  assign done    = (state_q == ST_CLOSE) & ~change & out_free;

  always_comb begin
    unique case (ctrl.op) inside
      OP_CLEAR, OP_LOAD: final_d = 1'b0;
      OP_STEP:           final_d = pass[MAX_ELEMS-1];
      OP_CLOSE:          final_d = final_q | pass[MAX_ELEMS-1];
      default:           final_d = final_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      final_q <= final_d;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      matched_q  <= ~ovf_q & act_all[count_q];
      overflow_q <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;
  assign overflow_o  = overflow_q;

  `DSPM_ASSERT_NOW(a_rise_from_close, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_CLOSE)
  `DSPM_ASSERT_NOW(a_ovf_no_match, clk_i, rst_ni, out_valid_q && overflow_q, !matched_q)
  `DSPM_ASSERT_NEXT(a_full_sets_ovf, clk_i, rst_ni, is_append && count_q == CNT_W'(MAX_ELEMS), ovf_q)
  `DSPM_ASSERT_NEXT(a_clear_resets, clk_i, rst_ni, accept && mode_i == MODE_CLEAR, count_q == '0 && !ovf_q && act_all == '0)

endmodule

`default_nettype wire
